[rtl/mpcc_pkg.sv]
package mpcc_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W  = $clog2(MAP_DEPTH);

  localparam int XY_W    = 12;
  localparam int HEAD_W  = 9;
  localparam int CELL_W  = 8;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;

  // width that holds both a config size and the compile-time maximum
  localparam int MAXDIM_W = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);
  localparam int DIM_W    = (MAXDIM_W > CFG_W) ? MAXDIM_W : CFG_W;

  localparam int TRIG_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = XY_W + TRIG_W;
  localparam int SUM_W   = 30;
  localparam int POS_W   = SUM_W - FRAC_W;

  localparam logic [CFG_W-1:0]  COLS_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0]  ROWS_RST = CFG_W'(1000);
  localparam logic [CELL_W-1:0] THR_RST  = CELL_W'(250);

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_START  = 2'd1,
    CMD_POINT  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MAP_COLS  = 2'd0,
    REG_MAP_ROWS  = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TRUNC,
    ST_READ,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic [1:0]             command;
    logic signed [XY_W-1:0] coord_x;
    logic signed [XY_W-1:0] coord_y;
    logic [HEAD_W-1:0]      heading_deg;
    logic signed [XY_W-1:0] target_x;
    logic signed [XY_W-1:0] target_y;
    logic [CELL_W-1:0]      cell_value;
  } mpcc_req_t;

  typedef struct packed {
    logic walkable;
    logic left_map;
    logic hit_obstacle;
  } mpcc_rsp_t;

  // round(sin(k deg) * 2^14), k = 0..90
  localparam logic [14:0] SIN_Q14 [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  function automatic logic [HEAD_W-1:0] mod360(input logic [HEAD_W-1:0] deg);
    return (deg >= HEAD_W'(360)) ? deg - HEAD_W'(360) : deg;
  endfunction

  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [HEAD_W-1:0] deg);
    logic [HEAD_W-1:0] d;
    logic [6:0]        idx;
    logic              neg;
    logic signed [TRIG_W-1:0] mag;
    d = mod360(deg);
    if (d <= HEAD_W'(90)) begin
      idx = d[6:0];
      neg = 1'b0;
    end else if (d <= HEAD_W'(180)) begin
      idx = 7'(HEAD_W'(180) - d);
      neg = 1'b0;
    end else if (d <= HEAD_W'(270)) begin
      idx = 7'(d - HEAD_W'(180));
      neg = 1'b1;
    end else begin
      idx = 7'(HEAD_W'(360) - d);
      neg = 1'b1;
    end
    mag = $signed({1'b0, SIN_Q14[idx]});
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [HEAD_W-1:0] deg);
    return sin_deg(mod360(deg) + HEAD_W'(90));
  endfunction

endpackage

[rtl/mpcc_ram.sv]
module mpcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/motion_primitive_collision_check.sv]
// Motion primitive collision check against a byte occupancy map.
//
// Commands enter on start_i/req_i and are taken when start_i is high and busy_o
// is low. A cell write (command 0) and a path start (command 1) finish in the
// cycle they are taken; busy_o stays low. A path point (command 2) keeps busy_o
// high through its steps, so a new point waits until the last is through:
// product stage, sum stage, truncation, map read and compare, with the single
// read port of the map memory as the one-per-item resource. A point arriving
// after the path left the map is taken and dropped, busy_o staying low. A finish
// (command 3) reads the target cell and raises done_o with the verdict on rsp_o;
// done_o lasts one cycle and the receiver cannot stall it.
// Configuration writes use cfg_valid_i/cfg_ready_o (always ready) and must only
// come while the block is idle. Reset restores the map size and threshold and
// clears the path state; the map contents are undefined until written and get
// no clearing pass.
module motion_primitive_collision_check
  import mpcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mpcc_req_t           req_i,
  output logic                done_o,
  output mpcc_rsp_t           rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  state_e state_q, state_d;

  logic [CFG_W-1:0]  map_cols_q, map_rows_q;
  logic [CELL_W-1:0] thr_q;

  logic signed [XY_W-1:0]   org_x_q, org_y_q, goal_x_q, goal_y_q;
  logic signed [TRIG_W-1:0] sin_q, cos_q;
  logic                     obst_q, out_q, fin_q, in_q;

  logic signed [PROD_W-1:0] pxs_q, pyc_q, pxc_q, pys_q;
  logic signed [PROD_W-1:0] pxs_d, pyc_d, pxc_d, pys_d;
  logic signed [SUM_W-1:0]  nx_q, ny_q, nx_d, ny_d, tx, ty;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q;

  logic                     accept, mem_we, mem_re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [CELL_W-1:0]        rdata;
  logic [DIM_W-1:0]         eff_cols, eff_rows, row_full;
  logic                     in_map;
  logic                     done_q;
  mpcc_rsp_t                rsp_q;
  logic                     walk;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cols_q <= COLS_RST;
      map_rows_q <= ROWS_RST;
      thr_q      <= THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAP_COLS:  map_cols_q <= cfg_data_i;
        REG_MAP_ROWS:  map_rows_q <= cfg_data_i;
        REG_THRESHOLD: thr_q      <= cfg_data_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_cols = (DIM_W'(map_cols_q) < DIM_W'(MAX_COLS)) ? DIM_W'(map_cols_q)
                                                            : DIM_W'(MAX_COLS);
  assign eff_rows = (DIM_W'(map_rows_q) < DIM_W'(MAX_ROWS)) ? DIM_W'(map_rows_q)
                                                            : DIM_W'(MAX_ROWS);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_e'(req_i.command) == CMD_POINT && !out_q) begin
            state_d = ST_SUM;
          end else if (cmd_e'(req_i.command) == CMD_FINISH) begin
            state_d = ST_READ;
          end
        end
      end
      ST_SUM:   state_d = ST_TRUNC;
      ST_TRUNC: state_d = ST_READ;
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy_o = 1'b1;
    mem_re = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy_o = 1'b0;
      ST_READ:  mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // cell write goes straight to the map, raw row and column
  assign mem_we = accept && cmd_e'(req_i.command) == CMD_WRITE
               && !req_i.coord_x[XY_W-1] && !req_i.coord_y[XY_W-1]
               && ((XY_W+1)'(req_i.coord_x) < (XY_W+1)'(MAX_COLS))
               && ((XY_W+1)'(req_i.coord_y) < (XY_W+1)'(MAX_ROWS));
  assign waddr = ADDR_W'(req_i.coord_y[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
               + ADDR_W'(req_i.coord_x[COL_W-1:0]);

  // path state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      sin_q    <= '0;
      cos_q    <= TRIG_W'(16384);
      obst_q   <= 1'b0;
      out_q    <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      if (accept && cmd_e'(req_i.command) == CMD_START) begin
        org_x_q  <= req_i.coord_x;
        org_y_q  <= req_i.coord_y;
        goal_x_q <= req_i.target_x;
        goal_y_q <= req_i.target_y;
        sin_q    <= sin_deg(req_i.heading_deg);
        cos_q    <= cos_deg(req_i.heading_deg);
        obst_q   <= 1'b0;
        out_q    <= 1'b0;
      end
      if (accept) begin
        fin_q <= cmd_e'(req_i.command) == CMD_FINISH;
      end
      if (state_q == ST_CHECK && !fin_q) begin
        if (!in_q) begin
          out_q <= 1'b1;
        end else if (rdata >= thr_q) begin
          obst_q <= 1'b1;
        end
      end
    end
  end

  // rotation products
  assign pxs_d = req_i.coord_x * sin_q;
  assign pyc_d = req_i.coord_y * cos_q;
  assign pxc_d = req_i.coord_x * cos_q;
  assign pys_d = req_i.coord_y * sin_q;

  assign nx_d = SUM_W'(pxs_q) + SUM_W'(pyc_q) + (SUM_W'(org_x_q) <<< FRAC_W);
  assign ny_d = SUM_W'(pys_q) - SUM_W'(pxc_q) + (SUM_W'(org_y_q) <<< FRAC_W);

  // bias negatives so the shift truncates toward zero
  assign tx = nx_q + (nx_q[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
  assign ty = ny_q + (ny_q[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));

  always_ff @(posedge clk_i) begin
    if (accept && cmd_e'(req_i.command) == CMD_POINT) begin
      pxs_q <= pxs_d;
      pyc_q <= pyc_d;
      pxc_q <= pxc_d;
      pys_q <= pys_d;
    end
    if (state_q == ST_SUM) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
    if (state_q == ST_TRUNC) begin
      pos_x_q <= POS_W'(tx >>> FRAC_W);
      pos_y_q <= POS_W'(ty >>> FRAC_W);
    end else if (accept && cmd_e'(req_i.command) == CMD_FINISH) begin
      pos_x_q <= POS_W'(goal_x_q);
      pos_y_q <= POS_W'(goal_y_q);
    end
    if (state_q == ST_READ) begin
      in_q <= in_map;
    end
  end

  // bounds and flipped row address
  assign in_map = !pos_x_q[POS_W-1] && !pos_y_q[POS_W-1]
               && (pos_x_q < $signed({{(POS_W-DIM_W){1'b0}}, eff_cols}))
               && (pos_y_q < $signed({{(POS_W-DIM_W){1'b0}}, eff_rows}));
  assign row_full = eff_rows - DIM_W'(1) - DIM_W'(pos_y_q);
  assign raddr    = ADDR_W'(row_full[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                  + ADDR_W'(pos_x_q[COL_W-1:0]);

  mpcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (req_i.cell_value),
    .re_i    (mem_re && in_map),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // verdict
  always_comb begin
    if (out_q) begin
      walk = 1'b0;
    end else if (!in_q) begin
      walk = 1'b1;
    end else if (rdata >= thr_q) begin
      walk = 1'b0;
    end else begin
      walk = !obst_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= state_q == ST_CHECK && fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK && fin_q) begin
      rsp_q.walkable     <= walk;
      rsp_q.left_map     <= out_q;
      rsp_q.hit_obstacle <= obst_q;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_CHECK && fin_q))
    else $error("result beat without a finish in check");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE)
    else $error("map write while a read is in flight");

  a_left_not_walkable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.left_map |-> !rsp_q.walkable)
    else $error("path left the map but reported walkable");

  a_finish_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_e'(req_i.command) == CMD_FINISH |=> busy_o && state_q == ST_READ)
    else $error("finish did not start the target read");

endmodule

[bench/mpcc_verdict_checker.sv]
`timescale 1ns / 100ps

module mpcc_verdict_checker
  import mpcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  mpcc_req_t        req_i,
  input  logic             done_i,
  input  mpcc_rsp_t        rsp_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               mismatch_cnt_o,
  output int               verdicts_due_o
);

  localparam longint Q14_ONE = 16384;
  localparam int unsigned RESET_COLS = 1000;
  localparam int unsigned RESET_ROWS = 1000;
  localparam int unsigned RESET_THR  = 250;

  // quarter-wave sine table, round(sin(k deg) * 2^14)
  int sine_q14 [91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  bit [CELL_W-1:0] grid [MAP_DEPTH];
  int unsigned     cols_cfg;
  int unsigned     rows_cfg;
  int unsigned     thr_cfg;
  int              org_x;
  int              org_y;
  int              goal_x;
  int              goal_y;
  int unsigned     head_deg;
  bit              obst_seen;
  bit              left_seen;
  mpcc_rsp_t       due_verdicts [$];
  int              mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] verdict mismatch: %s", $time, what);
  endtask

  function automatic int q14_sin(input int unsigned deg);
    int unsigned d;
    d = deg % 360;
    if (d <= 90) return sine_q14[d];
    if (d <= 180) return sine_q14[180 - d];
    if (d <= 270) return -sine_q14[d - 180];
    return -sine_q14[360 - d];
  endfunction

  function automatic longint span_cols();
    return (cols_cfg < MAX_COLS) ? cols_cfg : MAX_COLS;
  endfunction

  function automatic longint span_rows();
    return (rows_cfg < MAX_ROWS) ? rows_cfg : MAX_ROWS;
  endfunction

  function automatic bit on_map(input longint x, input longint y);
    return x >= 0 && x < span_cols() && y >= 0 && y < span_rows();
  endfunction

  // rows are stored top-down, so y counts up from the last row in use
  function automatic bit blocked(input longint x, input longint y);
    return grid[(span_rows() - 1 - y) * MAX_COLS + x] >= thr_cfg;
  endfunction

  task automatic follow_command(input mpcc_req_t r);
    int        cx;
    int        cy;
    longint    s;
    longint    c;
    longint    nx;
    longint    ny;
    mpcc_rsp_t v;
    cx = $signed(r.coord_x);
    cy = $signed(r.coord_y);
    case (r.command)
      CMD_WRITE: begin
        if (cx >= 0 && cx < MAX_COLS && cy >= 0 && cy < MAX_ROWS)
          grid[cy * MAX_COLS + cx] = r.cell_value;
      end
      CMD_START: begin
        org_x     = cx;
        org_y     = cy;
        head_deg  = r.heading_deg;
        goal_x    = $signed(r.target_x);
        goal_y    = $signed(r.target_y);
        obst_seen = 1'b0;
        left_seen = 1'b0;
      end
      CMD_POINT: begin
        if (!left_seen) begin
          s  = q14_sin(head_deg);
          c  = q14_sin(head_deg + 90);
          nx = longint'(cx) * s + longint'(cy) * c + longint'(org_x) * Q14_ONE;
          ny = -longint'(cx) * c + longint'(cy) * s + longint'(org_y) * Q14_ONE;
          // signed division truncates toward zero
          nx = nx / Q14_ONE;
          ny = ny / Q14_ONE;
          if (!on_map(nx, ny)) left_seen = 1'b1;
          else if (blocked(nx, ny)) obst_seen = 1'b1;
        end
      end
      default: begin
        if (left_seen) v.walkable = 1'b0;
        else if (!on_map(goal_x, goal_y)) v.walkable = 1'b1;
        else if (blocked(goal_x, goal_y)) v.walkable = 1'b0;
        else v.walkable = !obst_seen;
        v.left_map     = left_seen;
        v.hit_obstacle = obst_seen;
        due_verdicts.push_back(v);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mpcc_rsp_t want;
    if (!rst_ni) begin
      cols_cfg  = RESET_COLS;
      rows_cfg  = RESET_ROWS;
      thr_cfg   = RESET_THR;
      org_x     = 0;
      org_y     = 0;
      goal_x    = 0;
      goal_y    = 0;
      head_deg  = 0;
      obst_seen = 1'b0;
      left_seen = 1'b0;
      due_verdicts.delete();
      verdicts_due_o <= 0;
      mismatch_cnt_o <= mismatches;
    end else begin
      if (done_i !== 1'b0) begin
        if (due_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %b with none due", rsp_i));
        end else begin
          want = due_verdicts.pop_front();
          if (rsp_i.walkable !== want.walkable)
            report_mismatch($sformatf("walkable got %b want %b",
                                      rsp_i.walkable, want.walkable));
          if (rsp_i.left_map !== want.left_map)
            report_mismatch($sformatf("left_map got %b want %b",
                                      rsp_i.left_map, want.left_map));
          if (rsp_i.hit_obstacle !== want.hit_obstacle)
            report_mismatch($sformatf("hit_obstacle got %b want %b",
                                      rsp_i.hit_obstacle, want.hit_obstacle));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAP_COLS:  cols_cfg = cfg_data_i;
          REG_MAP_ROWS:  rows_cfg = cfg_data_i;
          REG_THRESHOLD: thr_cfg  = cfg_data_i[CELL_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) follow_command(req_i);
      verdicts_due_o <= due_verdicts.size();
      mismatch_cnt_o <= mismatches;
    end
  end

endmodule

[bench/motion_primitive_collision_check_tb.sv]
`timescale 1ns / 100ps

module motion_primitive_collision_check_tb;
  import mpcc_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int POINT_REACH     = 5;
  localparam int NUM_EDGE_PHASES = 7;
  localparam int NUM_RAND_PHASES = 6;
  localparam longint Q14_ONE     = 16384;
  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(3);

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  logic             busy_o;
  mpcc_req_t        req_i       = '0;
  logic             done_o;
  mpcc_rsp_t        rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  int mismatch_cnt;
  int verdicts_due;
  int cycle_cnt  = 0;
  int calm_left  = 0;
  int items_sent = 0;
  int span_x     = 0;
  int span_y     = 0;
  int path_ox    = 0;
  int path_oy    = 0;
  int path_hd    = 0;
  int path_gx    = 0;
  int path_gy    = 0;
  bit cell_written [MAP_DEPTH];

  // map size extremes: each register at its ends, with the other kept narrow
  int unsigned phase_cols [NUM_EDGE_PHASES] = '{1024, 2, 0, 2047, 3, 1, 1};
  int unsigned phase_rows [NUM_EDGE_PHASES] = '{2, 1024, 5, 1, 2047, 0, 1};
  int unsigned phase_thr  [NUM_EDGE_PHASES] = '{255, 0, 100, 200, 128, 1, 1};

  motion_primitive_collision_check u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  mpcc_verdict_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .req_i         (req_i),
    .done_i        (done_o),
    .rsp_i         (rsp_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatch_cnt_o(mismatch_cnt),
    .verdicts_due_o(verdicts_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // random gaps, with an occasional run of back-to-back beats
  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
    return $urandom_range(0, 13);
  endfunction

  function automatic int rand12();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int pick_x();
    if (span_x > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, span_x - 1);
    return rand12();
  endfunction

  function automatic int pick_y();
    if (span_y > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, span_y - 1);
    return rand12();
  endfunction

  function automatic int near_offset();
    return int'($urandom_range(0, 2 * POINT_REACH)) - POINT_REACH;
  endfunction

  // fields the command does not use carry random values
  function automatic mpcc_req_t make_req(input cmd_e cmd, input int x, input int y);
    mpcc_req_t r;
    r.command     = cmd;
    r.coord_x     = XY_W'(x);
    r.coord_y     = XY_W'(y);
    r.heading_deg = HEAD_W'($urandom_range(0, 511));
    r.target_x    = XY_W'($urandom);
    r.target_y    = XY_W'($urandom);
    r.cell_value  = CELL_W'($urandom);
    return r;
  endfunction

  task automatic push_item(input mpcc_req_t r);
    int gap;
    int cx;
    int cy;
    gap = draw_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    cx = $signed(r.coord_x);
    cy = $signed(r.coord_y);
    if (r.command == CMD_WRITE && cx >= 0 && cx < MAX_COLS && cy >= 0 && cy < MAX_ROWS)
      cell_written[cy * MAX_COLS + cx] = 1'b1;
  endtask

  // a path read must only ever see a cell that holds a written value
  task automatic cover_cell(input longint x, input longint y);
    mpcc_req_t r;
    int        col;
    int        row;
    if (x < 0 || x >= span_x || y < 0 || y >= span_y) return;
    col = int'(x);
    row = span_y - 1 - int'(y);
    if (cell_written[row * MAX_COLS + col]) return;
    r = make_req(CMD_WRITE, col, row);
    r.cell_value = CELL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 120));
    push_item(r);
  endtask

  // fill the cell a point or a finish will read just before it goes out
  task automatic send_item(input mpcc_req_t r);
    longint s;
    longint c;
    longint nx;
    longint ny;
    case (r.command)
      CMD_POINT: begin
        s  = longint'(sin_deg(HEAD_W'(path_hd)));
        c  = longint'(cos_deg(HEAD_W'(path_hd)));
        nx = longint'($signed(r.coord_x)) * s + longint'($signed(r.coord_y)) * c
           + longint'(path_ox) * Q14_ONE;
        ny = longint'($signed(r.coord_y)) * s - longint'($signed(r.coord_x)) * c
           + longint'(path_oy) * Q14_ONE;
        cover_cell(nx / Q14_ONE, ny / Q14_ONE);
      end
      CMD_FINISH: cover_cell(path_gx, path_gy);
      default: ;
    endcase
    push_item(r);
    if (r.command == CMD_START) begin
      path_ox = $signed(r.coord_x);
      path_oy = $signed(r.coord_y);
      path_hd = r.heading_deg;
      path_gx = $signed(r.target_x);
      path_gy = $signed(r.target_y);
    end
  endtask

  task automatic cell_write(input int x, input int y, input int unsigned val);
    mpcc_req_t r;
    r = make_req(CMD_WRITE, x, y);
    r.cell_value = CELL_W'(val);
    send_item(r);
  endtask

  task automatic path_start(input int x, input int y, input int unsigned hd,
                            input int tx, input int ty);
    mpcc_req_t r;
    r = make_req(CMD_START, x, y);
    r.heading_deg = HEAD_W'(hd);
    r.target_x    = XY_W'(tx);
    r.target_y    = XY_W'(ty);
    send_item(r);
  endtask

  task automatic path_point(input int x, input int y);
    send_item(make_req(CMD_POINT, x, y));
  endtask

  task automatic path_finish();
    send_item(make_req(CMD_FINISH, rand12(), rand12()));
  endtask

  // wait out every verdict in flight, then let a point still in flight finish its run
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_beat(input logic [IDX_W-1:0] idx, input int unsigned data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // cells get filled on demand as paths reach them
  task automatic program_map(input int unsigned cols, input int unsigned rows,
                             input int unsigned thr, input bit poke_spare);
    drain();
    if (poke_spare) cfg_beat(REG_SPARE, $urandom);
    cfg_beat(REG_MAP_COLS, cols);
    cfg_beat(REG_MAP_ROWS, rows);
    cfg_beat(REG_THRESHOLD, thr);
    cfg_valid_i <= 1'b0;
    span_x = (cols < MAX_COLS) ? cols : MAX_COLS;
    span_y = (rows < MAX_ROWS) ? rows : MAX_ROWS;
  endtask

  task automatic random_path();
    int ox;
    int oy;
    int tx;
    int ty;
    ox = (span_x > 0) ? $urandom_range(0, span_x - 1) : rand12();
    oy = (span_y > 0) ? $urandom_range(0, span_y - 1) : rand12();
    tx = ($urandom_range(0, 4) == 0) ? rand12() : pick_x();
    ty = ($urandom_range(0, 4) == 0) ? rand12() : pick_y();
    path_start(ox, oy, $urandom_range(0, 511), tx, ty);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 9) == 0) path_point(rand12(), rand12());
      else path_point(near_offset(), near_offset());
      if ($urandom_range(0, 11) == 0) cell_write(pick_x(), pick_y(), $urandom_range(0, 255));
    end
    if ($urandom_range(0, 9) != 0) path_finish();
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        7: cell_write(pick_x(), pick_y(), $urandom_range(0, 255));
        8: send_item(make_req(cmd_e'($urandom_range(0, 3)), rand12(), rand12()));
        9: path_finish();
        default: random_path();
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_map(16, 16, 128, 1'b1);
    // writes outside the store are dropped
    cell_write(-1, 3, 255);
    cell_write(1024, -2048, 1);
    cell_write(2047, 5, 255);
    cell_write(1023, 1023, 255);
    cell_write(3, 0, 0);
    cell_write(7, 10, 200);
    // finish and point with no path started
    path_finish();
    path_point(0, 0);
    path_finish();
    // heading 0, first point lands on the blocked cell
    path_start(5, 5, 0, 10, 10);
    path_point(0, 2);
    path_point(1, 1);
    path_finish();
    // blocked target, heading above a full turn
    cell_write(10, 5, 255);
    path_start(5, 5, 450, 10, 10);
    path_point(1, -1);
    path_finish();
    // leaves the map, later points are dropped, target outside
    path_start(8, 8, 180, -1, 16);
    path_point(2047, -2048);
    path_point(0, 0);
    path_finish();
    // target outside, which wins over any hit
    path_start(8, 8, 270, 16, -1);
    path_point(-2, 0);
    path_finish();
    path_start(2, 2, 511, 0, 0);
    path_point(-3, 4);
    path_finish();
    path_start(9, 3, 359, 2048 - 1, -2048);
    path_point(0, 0);
    path_finish();
    run_traffic(ITEMS_PER_PHASE);

    for (int p = 0; p < NUM_EDGE_PHASES; p++) begin
      program_map(phase_cols[p], phase_rows[p], phase_thr[p], p[0]);
      run_traffic(ITEMS_PER_PHASE);
    end
    repeat (NUM_RAND_PHASES) begin
      program_map($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 255),
                  $urandom_range(0, 1));
      run_traffic(ITEMS_PER_PHASE);
    end

    drain();
    if (mismatch_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[motion_primitive_collision_check.f]
rtl/mpcc_pkg.sv
rtl/mpcc_ram.sv
rtl/motion_primitive_collision_check.sv
bench/mpcc_verdict_checker.sv
bench/motion_primitive_collision_check_tb.sv
